// File: hw/rtl/mtsc_pkg.sv
// shared constants, register indexes and bit-twiddling helpers for the
// z-order texture swizzle copy block; no dependencies
package mtsc_pkg;

   localparam int unsigned MAX_TEX_DIM = 4096;

   localparam int unsigned COORD_W  = 12;
   localparam int unsigned DIM_W    = 13;
   localparam int unsigned TILE_W   = 4;
   localparam int unsigned PSIZE_W  = 3;
   localparam int unsigned TWID_W   = 32;
   localparam int unsigned SRC_W    = 28;
   localparam int unsigned DATA_W   = 64;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 13;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RECT_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RECT_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_STRIDE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TILE_LOG2   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_LOG2  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ETC_SWAP    = 3'd7;

   // effective pixel size codes
   localparam logic [PSIZE_W-1:0] PSIZE_1B  = 3'd0;
   localparam logic [PSIZE_W-1:0] PSIZE_2B  = 3'd1;
   localparam logic [PSIZE_W-1:0] PSIZE_4B  = 3'd2;
   localparam logic [PSIZE_W-1:0] PSIZE_16B = 3'd4;

   localparam logic [TWID_W-1:0] X_BITS = 32'hAAAA_AAAA;
   localparam logic [TWID_W-1:0] Y_BITS = 32'h5555_5555;

   localparam logic [DIM_W-1:0] DIM_ONE = 13'd1;
   localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_TEX_DIM);

   typedef struct packed {
      logic [COORD_W-1:0] origin_x;
      logic [COORD_W-1:0] origin_y;
      logic [DIM_W-1:0]   rect_width;
      logic [DIM_W-1:0]   rect_height;
      logic [DIM_W-1:0]   source_stride;
      logic [TILE_W-1:0]  tile_log2;
      logic [PSIZE_W-1:0] pixel_bytes_log2;
      logic               etc_swap;
   } csr_type;

   // spread the 12 coordinate bits onto the even bit positions
   function automatic logic [TWID_W-1:0] spread_bits(input logic [COORD_W-1:0] c);
      logic [TWID_W-1:0] v;
      v = {{(TWID_W-COORD_W){1'b0}}, c} & 32'h0000_ffff;
      v = (v ^ (v << 8)) & 32'h00ff_00ff;
      v = (v ^ (v << 4)) & 32'h0f0f_0f0f;
      v = (v ^ (v << 2)) & 32'h3333_3333;
      v = (v ^ (v << 1)) & 32'h5555_5555;
      return v;
   endfunction

   function automatic logic [31:0] swap_word(input logic [31:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

   // zero reads as one, anything above the texture limit saturates
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      r = d;
      if (d == '0) begin
         r = DIM_ONE;
      end else if (d > DIM_MAX) begin
         r = DIM_MAX;
      end
      return r;
   endfunction

   function automatic logic [PSIZE_W-1:0] eff_psize(input logic [PSIZE_W-1:0] p);
      return (p > PSIZE_16B) ? PSIZE_16B : p;
   endfunction

   // bits at and above the tile area count linearly
   function automatic logic [TWID_W-1:0] high_mask(input logic [TILE_W-1:0] tl);
      logic [TWID_W-1:0] area;
      area = TWID_W'(1) << {tl, 1'b0};
      return ~(area - TWID_W'(1));
   endfunction

   function automatic logic [DATA_W-1:0] lo_mask(input logic [PSIZE_W-1:0] ps);
      logic [DATA_W-1:0] m;
      case (ps)
         PSIZE_1B: m = 64'h0000_0000_0000_00ff;
         PSIZE_2B: m = 64'h0000_0000_0000_ffff;
         PSIZE_4B: m = 64'h0000_0000_ffff_ffff;
         default:  m = '1;
      endcase
      return m;
   endfunction

endpackage

// File: hw/rtl/morton_texture_swizzle_copy_top.sv
// top level of the z-order texture swizzle copy block: csr bank, traversal
// counters and result register; depends on mtsc_pkg
//
// The block takes source pixels of a rectangle in raster order, one item per
// cycle, and for each returns the byte offset in a z-order swizzled texture,
// the linear source byte offset, the pixel data (each 32-bit word of the low
// half byte-reversed in etc mode, masked to the pixel width) and a last flag
// on the final pixel. Throughput is one item per clock while req_stall is low;
// rsp_valid rises in the cycle after accept, set by the single result register.
// The result register is reloaded in the cycle it is taken, so req_stall is only
// high while a result sits in it and rsp_stall is high. Any csr write rearms the
// walk at the rectangle origin; write csrs only while no item is in flight.
// After the last pixel the counters rearm on their own.
module morton_texture_swizzle_copy_top
   import mtsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // csr write port
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   // pixel items in
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DATA_W-1:0]     req_pixel_lo,
   input  logic [DATA_W-1:0]     req_pixel_hi,
   // result items out
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [TWID_W-1:0]     rsp_dest_offset,
   output logic [SRC_W-1:0]      rsp_source_offset,
   output logic [DATA_W-1:0]     rsp_out_lo,
   output logic [DATA_W-1:0]     rsp_out_hi,
   output logic                  rsp_last
);

   // csr bank
   csr_type csr_ff, csr_in;

   // traversal state
   logic [TWID_W-1:0] x_twiddle_ff, x_twiddle_in;
   logic [TWID_W-1:0] y_twiddle_ff, y_twiddle_in;
   logic [DIM_W-1:0]  column_count_ff, column_count_in;
   logic [DIM_W-1:0]  row_count_ff, row_count_in;
   logic [SRC_W-1:0]  row_base_ff, row_base_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TWID_W-1:0] dest_ff, dest_in;
   logic [SRC_W-1:0]  src_ff, src_in;
   logic [DATA_W-1:0] lo_ff, lo_in;
   logic [DATA_W-1:0] hi_ff, hi_in;
   logic              last_ff, last_in;

   // derived settings
   logic [PSIZE_W-1:0] ps;
   logic [DIM_W-1:0]   w_eff, h_eff;
   logic [TWID_W-1:0]  hm, xmask, ymask;
   logic [TWID_W-1:0]  x_start;
   logic               req_acc;
   logic               row_end, rect_end;
   logic [DATA_W-1:0]  lo_sw;

   assign ps      = eff_psize(csr_ff.pixel_bytes_log2);
   assign w_eff   = eff_dim(csr_ff.rect_width);
   assign h_eff   = eff_dim(csr_ff.rect_height);
   assign hm      = high_mask(csr_ff.tile_log2);
   assign xmask   = X_BITS | hm;
   assign ymask   = Y_BITS | hm;
   assign x_start = spread_bits(csr_ff.origin_x) << 1;

   // result register frees up in the cycle it is taken
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_acc   = req_valid & ~req_stall;

   assign row_end  = ({1'b0, column_count_ff} + 14'd1) >= {1'b0, w_eff};
   assign rect_end = ({1'b0, row_count_ff} + 14'd1) >= {1'b0, h_eff};

   // result payload for the item at the head of the walk
   always_comb begin
      lo_sw = req_pixel_lo;
      if (csr_ff.etc_swap) begin
         lo_sw = {swap_word(req_pixel_lo[63:32]), swap_word(req_pixel_lo[31:0])};
      end
      dest_in = (x_twiddle_ff + y_twiddle_ff) << ps;
      src_in  = row_base_ff + (SRC_W'(column_count_ff) << ps);
      lo_in   = lo_sw & lo_mask(ps);
      hi_in   = (ps == PSIZE_16B) ? req_pixel_hi : '0;
      last_in = row_end & rect_end;
   end

   assign rsp_valid_in = req_acc | (rsp_valid_ff & rsp_stall);

   // csr writes and counter stepping
   always_comb begin
      csr_in           = csr_ff;
      x_twiddle_in     = x_twiddle_ff;
      y_twiddle_in     = y_twiddle_ff;
      column_count_in  = column_count_ff;
      row_count_in     = row_count_ff;
      row_base_in      = row_base_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_ORIGIN_X:    csr_in.origin_x         = csr_wr_data[COORD_W-1:0];
            REG_ORIGIN_Y:    csr_in.origin_y         = csr_wr_data[COORD_W-1:0];
            REG_RECT_WIDTH:  csr_in.rect_width       = csr_wr_data[DIM_W-1:0];
            REG_RECT_HEIGHT: csr_in.rect_height      = csr_wr_data[DIM_W-1:0];
            REG_SRC_STRIDE:  csr_in.source_stride    = csr_wr_data[DIM_W-1:0];
            REG_TILE_LOG2:   csr_in.tile_log2        = csr_wr_data[TILE_W-1:0];
            REG_PIXEL_LOG2:  csr_in.pixel_bytes_log2 = csr_wr_data[PSIZE_W-1:0];
            REG_ETC_SWAP:    csr_in.etc_swap         = csr_wr_data[0];
            default: csr_in = csr_ff;
         endcase
         // rearm at the origin with the new settings
         x_twiddle_in    = spread_bits(csr_in.origin_x) << 1;
         y_twiddle_in    = spread_bits(csr_in.origin_y);
         column_count_in = '0;
         row_count_in    = '0;
         row_base_in     = '0;
      end else if (req_acc) begin
         if (row_end) begin
            column_count_in = '0;
            x_twiddle_in    = x_start;
            if (rect_end) begin
               // last pixel: back to the origin
               y_twiddle_in = spread_bits(csr_ff.origin_y);
               row_count_in = '0;
               row_base_in  = '0;
            end else begin
               row_count_in = row_count_ff + DIM_ONE;
               y_twiddle_in = (y_twiddle_ff - ymask) & ymask;
               row_base_in  = row_base_ff + (SRC_W'(csr_ff.source_stride) << ps);
            end
         end else begin
            column_count_in = column_count_ff + DIM_ONE;
            x_twiddle_in    = (x_twiddle_ff - xmask) & xmask;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.origin_x         <= '0;
         csr_ff.origin_y         <= '0;
         csr_ff.rect_width       <= DIM_ONE;
         csr_ff.rect_height      <= DIM_ONE;
         csr_ff.source_stride    <= DIM_ONE;
         csr_ff.tile_log2        <= '0;
         csr_ff.pixel_bytes_log2 <= PSIZE_4B;
         csr_ff.etc_swap         <= 1'b0;
         x_twiddle_ff            <= '0;
         y_twiddle_ff            <= '0;
         column_count_ff         <= '0;
         row_count_ff            <= '0;
         row_base_ff             <= '0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         csr_ff          <= csr_in;
         x_twiddle_ff    <= x_twiddle_in;
         y_twiddle_ff    <= y_twiddle_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         row_base_ff     <= row_base_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_acc) begin
         dest_ff <= dest_in;
         src_ff  <= src_in;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_dest_offset   = dest_ff;
   assign rsp_source_offset = src_ff;
   assign rsp_out_lo        = lo_ff;
   assign rsp_out_hi        = hi_ff;
   assign rsp_last          = last_ff;

   // column position stays inside the row
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      column_count_ff < w_eff)
      else $error("column count past row width");

   // row position stays inside the rectangle
   a_row_in_rect: assert property (@(posedge clock) disable iff (reset)
      row_count_ff < h_eff)
      else $error("row count past rectangle height");

   // x counter never carries bits outside its mask
   a_x_masked: assert property (@(posedge clock) disable iff (reset)
      (x_twiddle_ff & ~xmask) == '0)
      else $error("x twiddle off its bit lanes");

   // the last pixel rearms the walk
   a_last_rearms: assert property (@(posedge clock) disable iff (reset)
      (req_acc && last_in && !csr_wr_en) |=>
         (column_count_ff == '0 && row_count_ff == '0 && row_base_ff == '0))
      else $error("walk not rearmed after last pixel");

endmodule

// File: sim/mtsc_tb_pkg.sv
`timescale 1ns / 1ps
// scoreboard class for the z-order texture swizzle copy testbench: keeps its own
// copy of the registers and the walk counters and a queue of expected results
// depends on mtsc_pkg for widths and register indexes
package mtsc_tb_pkg;
   import mtsc_pkg::*;

   typedef struct packed {
      logic [TWID_W-1:0] dest_offset;
      logic [SRC_W-1:0]  source_offset;
      logic [DATA_W-1:0] out_lo;
      logic [DATA_W-1:0] out_hi;
      logic              last;
   } pixel_place_type;

   class swizzle_tracker;
      csr_type           cfg;
      logic [TWID_W-1:0] x_twid;
      logic [TWID_W-1:0] y_twid;
      logic [DIM_W-1:0]  col;
      logic [DIM_W-1:0]  row;
      logic [SRC_W-1:0]  row_base;
      pixel_place_type   pending[$];
      int unsigned       errors;
      int unsigned       checked;
      int unsigned       rects_done;
      int unsigned       src_wraps;

      function new();
         cfg = '0;
         cfg.rect_width = DIM_ONE;
         cfg.rect_height = DIM_ONE;
         cfg.source_stride = DIM_ONE;
         cfg.pixel_bytes_log2 = PSIZE_4B;
         errors = 0;
         checked = 0;
         rects_done = 0;
         src_wraps = 0;
         restart();
      endfunction

      // coordinate bits onto the even positions
      function logic [TWID_W-1:0] interleave(logic [COORD_W-1:0] c);
         logic [TWID_W-1:0] v;
         v = '0;
         for (int i = 0; i < COORD_W; i++) v[2*i] = c[i];
         return v;
      endfunction

      function logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] d);
         if (d == '0) return DIM_ONE;
         if (d > MAX_TEX_DIM) return DIM_MAX;
         return d;
      endfunction

      function void restart();
         x_twid = interleave(cfg.origin_x) << 1;
         y_twid = interleave(cfg.origin_y);
         col = '0;
         row = '0;
         row_base = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
         case (idx)
            REG_ORIGIN_X:    cfg.origin_x = d[COORD_W-1:0];
            REG_ORIGIN_Y:    cfg.origin_y = d[COORD_W-1:0];
            REG_RECT_WIDTH:  cfg.rect_width = d[DIM_W-1:0];
            REG_RECT_HEIGHT: cfg.rect_height = d[DIM_W-1:0];
            REG_SRC_STRIDE:  cfg.source_stride = d[DIM_W-1:0];
            REG_TILE_LOG2:   cfg.tile_log2 = d[TILE_W-1:0];
            REG_PIXEL_LOG2:  cfg.pixel_bytes_log2 = d[PSIZE_W-1:0];
            REG_ETC_SWAP:    cfg.etc_swap = d[0];
            default: ;
         endcase
         restart();
      endfunction

      // place one accepted pixel and advance the walk
      function void note_pixel(logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi);
         pixel_place_type   p;
         int unsigned       ps;
         logic [TWID_W-1:0] linear;
         logic [TWID_W-1:0] xm;
         logic [TWID_W-1:0] ym;
         logic [DIM_W-1:0]  w;
         logic [DIM_W-1:0]  h;
         logic [SRC_W-1:0]  old_base;
         ps = (cfg.pixel_bytes_log2 > 4) ? 4 : cfg.pixel_bytes_log2;
         w = clamp_dim(cfg.rect_width);
         h = clamp_dim(cfg.rect_height);
         linear = ~((32'd1 << (2 * cfg.tile_log2)) - 32'd1);
         xm = X_BITS | linear;
         ym = Y_BITS | linear;
         p.dest_offset = (x_twid + y_twid) << ps;
         p.source_offset = row_base + (SRC_W'(col) << ps);
         p.out_lo = lo;
         if (cfg.etc_swap) begin
            for (int b = 0; b < 4; b++) begin
               p.out_lo[8*b +: 8] = lo[8*(3-b) +: 8];
               p.out_lo[32+8*b +: 8] = lo[32+8*(3-b) +: 8];
            end
         end
         if (ps < 3) p.out_lo &= (64'd1 << (8 << ps)) - 64'd1;
         p.out_hi = (ps == 4) ? hi : '0;
         p.last = 1'b0;
         if (col + 1 >= w) begin
            if (row + 1 >= h) begin
               p.last = 1'b1;
               rects_done++;
               restart();
            end else begin
               col = '0;
               x_twid = interleave(cfg.origin_x) << 1;
               row++;
               y_twid = (y_twid - ym) & ym;
               old_base = row_base;
               row_base = row_base + (SRC_W'(cfg.source_stride) << ps);
               if (row_base < old_base) src_wraps++;
            end
         end else begin
            col++;
            x_twid = (x_twid - xm) & xm;
         end
         pending.push_back(p);
      endfunction

      task report(string what);
         if (errors < 100) $display("mismatch: %s", what);
         errors++;
      endtask

      task check_result(pixel_place_type got);
         pixel_place_type want;
         if (pending.size() == 0) begin
            report($sformatf("result with nothing expected, dest_offset %h", got.dest_offset));
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.dest_offset !== want.dest_offset)
            report($sformatf("result %0d dest_offset %h, expected %h",
                             checked, got.dest_offset, want.dest_offset));
         if (got.source_offset !== want.source_offset)
            report($sformatf("result %0d source_offset %h, expected %h",
                             checked, got.source_offset, want.source_offset));
         if (got.out_lo !== want.out_lo)
            report($sformatf("result %0d out_lo %h, expected %h",
                             checked, got.out_lo, want.out_lo));
         if (got.out_hi !== want.out_hi)
            report($sformatf("result %0d out_hi %h, expected %h",
                             checked, got.out_hi, want.out_hi));
         if (got.last !== want.last)
            report($sformatf("result %0d last %b, expected %b", checked, got.last, want.last));
      endtask

      task flush_check();
         if (pending.size() != 0)
            report($sformatf("%0d expected results never arrived", pending.size()));
      endtask
   endclass

endpackage

// File: sim/testbench.sv
`timescale 1ns / 1ps
// top of the z-order texture swizzle copy testbench: clock, reset, stimulus,
// stall generation and the handshake monitor; depends on mtsc_pkg and mtsc_tb_pkg
module testbench;
   import mtsc_pkg::*;
   import mtsc_tb_pkg::*;

   // cycles without any handshake before the run is declared hung
   localparam int unsigned STALL_LIMIT  = 500;
   // random pixel items, the last stretch of them with no idling at all
   localparam int unsigned TARGET_ITEMS = 1150;
   localparam int unsigned CALM_ITEMS   = 200;
   // one-pixel rows at the widest stride: large row steps of the source offset
   localparam int unsigned WRAP_ROWS    = 200;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_ORIGIN_X;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [DATA_W-1:0]     req_pixel_lo = '0;
   logic [DATA_W-1:0]     req_pixel_hi = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [TWID_W-1:0]     rsp_dest_offset;
   logic [SRC_W-1:0]      rsp_source_offset;
   logic [DATA_W-1:0]     rsp_out_lo;
   logic [DATA_W-1:0]     rsp_out_hi;
   logic                  rsp_last;

   swizzle_tracker tracker = new();

   int unsigned sent_items = 0;
   int unsigned random_items = 0;
   int unsigned csr_writes = 0;
   int unsigned settings_count = 0;
   int unsigned quiet_cycles = 0;
   // random idling on the sending and receiving side
   bit          send_gaps = 1'b0;
   bit          rsp_gaps = 1'b0;

   morton_texture_swizzle_copy_top uut (
      .clock,
      .reset,
      .csr_wr_en,
      .csr_index,
      .csr_wr_data,
      .req_valid,
      .req_stall,
      .req_pixel_lo,
      .req_pixel_hi,
      .rsp_valid,
      .rsp_stall,
      .rsp_dest_offset,
      .rsp_source_offset,
      .rsp_out_lo,
      .rsp_out_hi,
      .rsp_last
   );

   always #6 clock = ~clock;

   // monitor: everything is sampled at the rising edge, before the nonblocking
   // updates of that edge land, so it sees exactly what the block saw
   always @(posedge clock) begin : watch
      pixel_place_type got;
      if (!reset) begin
         // a register write rearms the walk, both in the block and here
         if (csr_wr_en) begin
            tracker.write_reg(csr_index, csr_wr_data);
         end
         // expectation is queued before any check of the same edge
         if (req_valid && !req_stall) begin
            tracker.note_pixel(req_pixel_lo, req_pixel_hi);
         end
         if (rsp_valid && !rsp_stall) begin
            got.dest_offset = rsp_dest_offset;
            got.source_offset = rsp_source_offset;
            got.out_lo = rsp_out_lo;
            got.out_hi = rsp_out_hi;
            got.last = rsp_last;
            tracker.check_result(got);
         end
         // watchdog on handshake progress
         if (csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
               $display("morton_texture_swizzle_copy_top verification failed");
               $finish;
            end
         end
      end
   end

   // receiver: random stall bursts while enabled
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_gaps && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [CSR_DATA_W-1:0] pick_csr(int unsigned lo, int unsigned hi);
      return CSR_DATA_W'($urandom_range(lo, hi));
   endfunction

   // mostly small rectangles, now and then zero or at or beyond the texture limit
   function automatic logic [CSR_DATA_W-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return pick_csr(MAX_TEX_DIM, 8191);
         default: return pick_csr(1, 8);
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_pixel();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // one item on the request side; valid stays up across back-to-back items
   task automatic send_pixel(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
      if (send_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_lo <= lo;
      req_pixel_hi <= hi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
   endtask

   // hold the sender until every queued result has come back, then let the
   // result register settle
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (tracker.checked < sent_items) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= d;
      @(posedge clock);
      csr_writes++;
   endtask

   task automatic program_all(input logic [CSR_DATA_W-1:0] ox, input logic [CSR_DATA_W-1:0] oy,
                              input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h,
                              input logic [CSR_DATA_W-1:0] stride,
                              input logic [CSR_DATA_W-1:0] tile,
                              input logic [CSR_DATA_W-1:0] psize,
                              input logic [CSR_DATA_W-1:0] swap);
      wait_for_results();
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_RECT_WIDTH, w);
      write_reg(REG_RECT_HEIGHT, h);
      write_reg(REG_SRC_STRIDE, stride);
      write_reg(REG_TILE_LOG2, tile);
      write_reg(REG_PIXEL_LOG2, psize);
      write_reg(REG_ETC_SWAP, swap);
      csr_wr_en <= 1'b0;
      settings_count++;
   endtask

   task automatic program_one(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      wait_for_results();
      write_reg(idx, d);
      csr_wr_en <= 1'b0;
      settings_count++;
   endtask

   initial begin : stimulus
      int unsigned count;
      int unsigned pause_at;
      bit          calm;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: a one-pixel rectangle, so every item is the last one
      send_pixel('1, '1);
      send_pixel('0, '0);

      // far corner of the texture, whole-area tile, 16-byte pixels with etc swap
      // and a zero stride so every row reads the same source row
      program_all(4095, 4095, 3, 2, 0, 15, CSR_DATA_W'(PSIZE_16B), 1);
      send_pixel('1, '1);
      send_pixel('0, '0);
      send_pixel(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
      send_pixel(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
      send_pixel(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      send_pixel(pick_pixel(), pick_pixel());
      // sender holds until the block has drained
      wait_for_results();

      // zero width reads as one, oversized height saturates, pixel code above
      // the largest size acts as 16 bytes, origin bit beyond the field is dropped
      program_all(13'h1fff, 13'h1000, 0, 8191, 13'h1fff, 0, 7, 0);
      repeat (4) send_pixel(pick_pixel(), pick_pixel());

      // byte pixels with swap: only the low byte survives
      program_all(0, 0, CSR_DATA_W'(MAX_TEX_DIM), CSR_DATA_W'(MAX_TEX_DIM + 1), 1, 1,
                  CSR_DATA_W'(PSIZE_1B), 1);
      repeat (3) send_pixel(64'h1122_3344_5566_7788, '1);

      // single-register writes also rearm the walk
      program_one(REG_PIXEL_LOG2, CSR_DATA_W'(PSIZE_2B));
      repeat (3) send_pixel(pick_pixel(), pick_pixel());
      program_one(REG_PIXEL_LOG2, 3);
      repeat (3) send_pixel(pick_pixel(), pick_pixel());
      program_one(REG_ETC_SWAP, 0);
      repeat (2) send_pixel(pick_pixel(), pick_pixel());

      // one pixel per row at the widest stride
      send_gaps = 1'b1;
      rsp_gaps = 1'b1;
      program_all(0, 0, 1, CSR_DATA_W'(MAX_TEX_DIM), 8191, 15, CSR_DATA_W'(PSIZE_16B), 0);
      repeat (WRAP_ROWS) send_pixel(pick_pixel(), pick_pixel());

      // random settings, each followed by a short burst of pixels; some phases
      // touch only a few registers, some pause mid-way for the block to drain
      while (random_items < TARGET_ITEMS) begin
         calm = (random_items + CALM_ITEMS >= TARGET_ITEMS);
         send_gaps = !calm && ($urandom_range(0, 3) != 0);
         rsp_gaps = !calm && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) == 0) begin
            wait_for_results();
            repeat ($urandom_range(1, 3)) begin
               write_reg(CSR_IDX_W'($urandom_range(0, 7)), pick_csr(0, 8191));
            end
            csr_wr_en <= 1'b0;
            settings_count++;
         end else begin
            program_all(pick_csr(0, 8191), pick_csr(0, 8191), pick_dim(), pick_dim(),
                        pick_csr(0, 8191), pick_csr(0, 15), pick_csr(0, 7), pick_csr(0, 1));
         end
         count = $urandom_range(10, 60);
         pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, count - 1) : count;
         for (int i = 0; i < count; i++) begin
            if (i == pause_at) wait_for_results();
            send_pixel(pick_pixel(), pick_pixel());
            random_items++;
         end
      end

      // drain and let the result register settle before the verdict
      wait_for_results();
      repeat (4) @(posedge clock);
      tracker.flush_check();
      $display("sent %0d pixel items across %0d register settings (%0d csr writes)",
               sent_items, settings_count, csr_writes);
      $display("%0d results compared, %0d rectangles completed, source offset wrapped %0d times",
               tracker.checked, tracker.rects_done, tracker.src_wraps);
      if (tracker.errors == 0) begin
         $display("morton_texture_swizzle_copy_top verification clean");
      end else begin
         $display("morton_texture_swizzle_copy_top verification failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/mtsc_pkg.sv
hw/rtl/morton_texture_swizzle_copy_top.sv
sim/mtsc_tb_pkg.sv
sim/testbench.sv
